// ===== design/parabola_breakpoint_x_defines.svh =====
// ============================================================================
// Assertion macros for the parabola breakpoint block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef PARABOLA_BREAKPOINT_X_DEFINES_SVH
`define PARABOLA_BREAKPOINT_X_DEFINES_SVH

// Check a condition at every edge.
`define PBX_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define PBX_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the next cycle.
`define PBX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pbx_pkg.sv =====
// ============================================================================
// pbx_pkg
// Widths, codes and the per-item context shared by the breakpoint pipeline.
// ============================================================================
package pbx_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COORD_WIDTH = 32;
	localparam int CW          = COORD_WIDTH;

	localparam int THR_W  = 16;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int IDX_W  = ADDR_W - 2;

	localparam int MAG_W  = CW;
	localparam int HALF_W = (MAG_W + 1) / 2;
	localparam int HI_W   = MAG_W - HALF_W;
	localparam int PROD_W = 2 * MAG_W;
	localparam int R_W    = 2 * CW + 1;
	localparam int RAD_W  = 4 * CW + 2;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int N_W    = 2 * CW + 2;
	localparam int NS_W   = 2 * CW + 3;
	localparam int Q_W    = NS_W - 1;
	localparam int X_W    = Q_W + 1;
	localparam int EP_W   = 3 * CW;
	localparam int LHS_W  = R_W + FRAC_BITS;
	localparam int CMP_W  = 3 * CW + FRAC_BITS + 1;

	localparam logic [IDX_W-1:0] REG_THR   = '0;
	localparam logic [THR_W-1:0] THR_RESET = 1;

	localparam logic [2:0] ST_NORMAL = 3'd0;
	localparam logic [2:0] ST_LEFT   = 3'd1;
	localparam logic [2:0] ST_RIGHT  = 3'd2;
	localparam logic [2:0] ST_NOROOT = 3'd3;
	localparam logic [2:0] ST_EQUAL  = 3'd4;

	localparam logic signed [CW-1:0] X_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] X_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic [2:0]             status;
		logic signed [CW-1:0]   alt;
		logic signed [CW-1:0]   lx;
		logic signed [CW-1:0]   rx;
		logic signed [N_W-1:0]  n;
		logic [CW-1:0]          dm;
		logic                   dneg;
	} pbx_ctx_t;

	function automatic logic [CW-1:0] mag_of(input logic signed [CW:0] v);
		logic signed [CW:0] t;
		t = v[CW] ? -v : v;
		return t[CW-1:0];
	endfunction

endpackage

// ===== design/pbx_mul.sv =====
// ============================================================================
// pbx_mul
// Two-stage unsigned multiplier built from four half-width partial products.
// ============================================================================
module pbx_mul import pbx_pkg::*; (
	input  logic              clk,
	input  logic              adv,
	input  logic [MAG_W-1:0]  a,
	input  logic [MAG_W-1:0]  b,
	output logic [PROD_W-1:0] p
);

	logic [2*HALF_W-1:0]    ll_s1;
	logic [HALF_W+HI_W-1:0] lh_s1;
	logic [HALF_W+HI_W-1:0] hl_s1;
	logic [2*HI_W-1:0]      hh_s1;
	logic [PROD_W-1:0]      p_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ll_s1 <= a[HALF_W-1:0] * b[HALF_W-1:0];
			lh_s1 <= a[HALF_W-1:0] * b[MAG_W-1:HALF_W];
			hl_s1 <= a[MAG_W-1:HALF_W] * b[HALF_W-1:0];
			hh_s1 <= a[MAG_W-1:HALF_W] * b[MAG_W-1:HALF_W];
			p_s2  <= PROD_W'(ll_s1) + (PROD_W'(lh_s1) << HALF_W)
				+ (PROD_W'(hl_s1) << HALF_W) + (PROD_W'(hh_s1) << (2 * HALF_W));
		end
	end

	assign p = p_s2;

endmodule

// ===== design/pbx_solve.sv =====
// ============================================================================
// pbx_solve
// Root pipeline, twin floor dividers, root choice and saturation.
// ============================================================================
module pbx_solve import pbx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [RAD_W-1:0]     rad,
	input  pbx_ctx_t             ctx,
	output logic                 out_valid,
	output logic signed [CW-1:0] out_x,
	output logic [2:0]           out_status,
	output logic                 out_sat
);

	localparam int SQ_N = ROOT_W;
	localparam int DV_N = Q_W;

	typedef struct packed {
		logic [RAD_W-1:0]  x;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		pbx_ctx_t          ctx;
	} sq_t;

	typedef struct packed {
		logic [Q_W-1:0] u1;
		logic [Q_W-1:0] u2;
		logic [CW-1:0]  r1;
		logic [CW-1:0]  r2;
		logic           neg1;
		logic           neg2;
		pbx_ctx_t       ctx;
	} dv_t;

	sq_t             sq_src [SQ_N];
	sq_t             sq_d   [SQ_N];
	sq_t             sq_s   [SQ_N];
	logic [SQ_N-1:0] sq_v_s;

	logic signed [NS_W-1:0] m1_sa, m2_sa;
	pbx_ctx_t               ctx_sa;
	logic                   v_sa;

	dv_t             dv_b;
	dv_t             dv_src [DV_N];
	dv_t             dv_d   [DV_N];
	dv_t             dv_s   [DV_N];
	logic [DV_N-1:0] dv_v_s;

	logic signed [X_W-1:0] x_sc;
	pbx_ctx_t              ctx_sc;
	logic                  v_sc;

	logic signed [CW-1:0] x_sd;
	logic [2:0]           st_sd;
	logic                 sat_sd;
	logic                 v_sd;

	// Square root: one result bit per stage.
	always_comb begin
		logic [REM_W+1:0] t;
		logic [REM_W+1:0] tr;
		sq_src[0] = '{x: rad, rem: '0, root: '0, ctx: ctx};
		for (int k = 1; k < SQ_N; k++) sq_src[k] = sq_s[k-1];
		for (int k = 0; k < SQ_N; k++) begin
			t  = {sq_src[k].rem, sq_src[k].x[RAD_W-1:RAD_W-2]};
			tr = {2'b00, sq_src[k].root, 2'b01};
			sq_d[k].x   = {sq_src[k].x[RAD_W-3:0], 2'b00};
			sq_d[k].ctx = sq_src[k].ctx;
			if (t >= tr) begin
				t = t - tr;
				sq_d[k].root = {sq_src[k].root[ROOT_W-2:0], 1'b1};
			end else begin
				sq_d[k].root = {sq_src[k].root[ROOT_W-2:0], 1'b0};
			end
			sq_d[k].rem = t[REM_W-1:0];
		end
	end

	// Prepare numerators for floor division by a positive divisor.
	always_comb begin
		logic signed [NS_W-1:0] mp1, mp2;
		mp1 = ctx_sa.dneg ? -m1_sa : m1_sa;
		mp2 = ctx_sa.dneg ? -m2_sa : m2_sa;
		dv_b.neg1 = mp1[NS_W-1];
		dv_b.neg2 = mp2[NS_W-1];
		dv_b.u1   = mp1[NS_W-1] ? ~mp1[Q_W-1:0] : mp1[Q_W-1:0];
		dv_b.u2   = mp2[NS_W-1] ? ~mp2[Q_W-1:0] : mp2[Q_W-1:0];
		dv_b.r1   = '0;
		dv_b.r2   = '0;
		dv_b.ctx  = ctx_sa;
	end

	// Restoring division: one quotient bit per stage for both roots.
	always_comb begin
		logic [CW:0] t1, t2;
		logic        q1, q2;
		dv_src[0] = dv_b;
		for (int k = 1; k < DV_N; k++) dv_src[k] = dv_s[k-1];
		for (int k = 0; k < DV_N; k++) begin
			t1 = {dv_src[k].r1, dv_src[k].u1[Q_W-1]};
			t2 = {dv_src[k].r2, dv_src[k].u2[Q_W-1]};
			q1 = (t1 >= {1'b0, dv_src[k].ctx.dm});
			q2 = (t2 >= {1'b0, dv_src[k].ctx.dm});
			if (q1) t1 = t1 - {1'b0, dv_src[k].ctx.dm};
			if (q2) t2 = t2 - {1'b0, dv_src[k].ctx.dm};
			dv_d[k]    = dv_src[k];
			dv_d[k].r1 = t1[CW-1:0];
			dv_d[k].r2 = t2[CW-1:0];
			dv_d[k].u1 = {dv_src[k].u1[Q_W-2:0], q1};
			dv_d[k].u2 = {dv_src[k].u2[Q_W-2:0], q2};
		end
	end

	always_ff @(posedge clk) begin
		logic signed [X_W-1:0] x1, x2, lxe, rxe, xmx, xmn;
		if (adv) begin
			for (int k = 0; k < SQ_N; k++) sq_s[k] <= sq_d[k];
			m1_sa  <= {sq_s[SQ_N-1].ctx.n[N_W-1], sq_s[SQ_N-1].ctx.n}
				+ {2'b00, sq_s[SQ_N-1].root};
			m2_sa  <= {sq_s[SQ_N-1].ctx.n[N_W-1], sq_s[SQ_N-1].ctx.n}
				- {2'b00, sq_s[SQ_N-1].root};
			ctx_sa <= sq_s[SQ_N-1].ctx;
			dv_s[0] <= dv_d[0];
			for (int k = 1; k < DV_N; k++) dv_s[k] <= dv_d[k];
			// Undo the complement on negative quotients, then pick the root.
			x1  = dv_s[DV_N-1].neg1 ? ~{1'b0, dv_s[DV_N-1].u1} : {1'b0, dv_s[DV_N-1].u1};
			x2  = dv_s[DV_N-1].neg2 ? ~{1'b0, dv_s[DV_N-1].u2} : {1'b0, dv_s[DV_N-1].u2};
			lxe = {{(X_W-CW){dv_s[DV_N-1].ctx.lx[CW-1]}}, dv_s[DV_N-1].ctx.lx};
			rxe = {{(X_W-CW){dv_s[DV_N-1].ctx.rx[CW-1]}}, dv_s[DV_N-1].ctx.rx};
			x_sc   <= (lxe < x1 && x1 < rxe) ? x1 : x2;
			ctx_sc <= dv_s[DV_N-1].ctx;
			xmx = {{(X_W-CW){X_MAX[CW-1]}}, X_MAX};
			xmn = {{(X_W-CW){X_MIN[CW-1]}}, X_MIN};
			st_sd <= ctx_sc.status;
			if (ctx_sc.status != ST_NORMAL) begin
				x_sd   <= ctx_sc.alt;
				sat_sd <= 1'b0;
			end else if (x_sc > xmx) begin
				x_sd   <= X_MAX;
				sat_sd <= 1'b1;
			end else if (x_sc < xmn) begin
				x_sd   <= X_MIN;
				sat_sd <= 1'b1;
			end else begin
				x_sd   <= x_sc[CW-1:0];
				sat_sd <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s <= '0;
			v_sa   <= 1'b0;
			dv_v_s <= '0;
			v_sc   <= 1'b0;
			v_sd   <= 1'b0;
		end else if (adv) begin
			sq_v_s <= {sq_v_s[SQ_N-2:0], in_valid};
			v_sa   <= sq_v_s[SQ_N-1];
			dv_v_s <= {dv_v_s[DV_N-2:0], v_sa};
			v_sc   <= dv_v_s[DV_N-1];
			v_sd   <= v_sc;
		end
	end

	assign out_valid  = v_sd;
	assign out_x      = x_sd;
	assign out_status = st_sd;
	assign out_sat    = sat_sd;

endmodule

// ===== design/parabola_breakpoint_x.sv =====
// ============================================================================
// parabola_breakpoint_x
// Breakpoint x of two sweep-line parabolas, fully pipelined.
// ============================================================================
// The block takes one transaction per clock while the pipeline advances: a
// left site, a right site and a sweep height, all signed Q16.16, and returns
// one result transaction with the breakpoint x, a status code and a
// saturation flag. Results leave in order, after the root pipeline (one
// result bit per stage, 2W+1 stages) and the two floor dividers that run side
// by side (one quotient bit per stage, 2W+2 stages). A stalled output only
// freezes the pipeline when a finished result is about to collide with one
// still waiting, so input is still taken while bubbles drain. The threshold
// register sits at byte address 0 of the APB port (reset value 1) and is
// sampled with each item.
`include "parabola_breakpoint_x_defines.svh"

module parabola_breakpoint_x import pbx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic signed [CW-1:0] left_x,
	input  logic signed [CW-1:0] left_y,
	input  logic signed [CW-1:0] right_x,
	input  logic signed [CW-1:0] right_y,
	input  logic signed [CW-1:0] sweep_y,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic signed [CW-1:0] break_x,
	output logic [2:0]           status,
	output logic                 saturated
);

	typedef struct packed {
		logic signed [CW-1:0] lx;
		logic signed [CW-1:0] rx;
		logic [THR_W-1:0]     thr;
		logic                 ldeg;
		logic                 rdeg;
		logic                 peq;
		logic                 pqneg;
		logic                 qlxneg;
		logic                 prxneg;
		logic [CW-1:0]        dm;
		logic                 dneg;
	} side_t;

	// Configuration register
	logic [THR_W-1:0] thr_q;
	logic             wr_en;

	assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_THR);
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1:2] == REG_THR) ? {{(DATA_W-THR_W){1'b0}}, thr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (wr_en) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// Pipeline advance: hold everything only when the last stage has a result
	// and the output register still holds one that has not been taken.
	logic adv;
	logic fin_valid;
	logic signed [CW-1:0] fin_x;
	logic [2:0] fin_status;
	logic fin_sat;

	logic                 result_valid_q;
	logic signed [CW-1:0] break_x_q;
	logic [2:0]           status_q;
	logic                 saturated_q;

	assign adv        = !fin_valid || !result_valid_q || result_ready;
	assign item_ready = adv;

	// Stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	logic signed [CW-1:0] lx_s1, ly_s1, rx_s1, ry_s1, sy_s1;
	logic [THR_W-1:0]     thr_s1, thr_s2;

	logic signed [CW:0]   p_s2, q_s2, dx_s2, dy_s2, qmp_s2;
	logic signed [CW-1:0] lx_s2, rx_s2;

	logic [CW-1:0] pm_s3, qm_s3, dxm_s3, dym_s3, lxm_s3, rxm_s3;
	side_t side_s3, side_s4, side_s5, side_s6, side_s7, side_s8, side_s9;

	logic [PROD_W-1:0] dx2_p, dy2_p, pq_p, qlx_p, prx_p;

	logic [R_W-1:0]        r_s6, r_s7, r_s8;
	logic [PROD_W-1:0]     pq_s6, pq_s7, pq_s8;
	logic signed [N_W-1:0] n_s6, n_s7, n_s8, n_s9;

	logic [PROD_W-1:0] eplo_p, ephi_p, m0r0_p, m0r1_p, m1r0_p, m1r1_p;

	logic [PROD_W-1:0] lo_s9;
	logic [PROD_W:0]   mid_s9, hi_s9;
	logic [EP_W-1:0]   ep_s9;
	logic [LHS_W-1:0]  lhs_s9;
	logic              pqneg_s9;

	logic [RAD_W-1:0] rad_s10;
	pbx_ctx_t         ctx_s10;

	// Stage 1: register the transaction and the threshold with it.
	always_ff @(posedge clk) begin
		if (adv) begin
			lx_s1  <= left_x;
			ly_s1  <= left_y;
			rx_s1  <= right_x;
			ry_s1  <= right_y;
			sy_s1  <= sweep_y;
			thr_s1 <= thr_q;
		end
	end

	// Stage 2: heights above the sweep line and site differences.
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2   <= {ly_s1[CW-1], ly_s1} - {sy_s1[CW-1], sy_s1};
			q_s2   <= {ry_s1[CW-1], ry_s1} - {sy_s1[CW-1], sy_s1};
			dx_s2  <= {lx_s1[CW-1], lx_s1} - {rx_s1[CW-1], rx_s1};
			dy_s2  <= {ly_s1[CW-1], ly_s1} - {ry_s1[CW-1], ry_s1};
			qmp_s2 <= {ry_s1[CW-1], ry_s1} - {ly_s1[CW-1], ly_s1};
			lx_s2  <= lx_s1;
			rx_s2  <= rx_s1;
			thr_s2 <= thr_s1;
		end
	end

	// Stage 3: magnitudes, signs and the degenerate tests.
	always_ff @(posedge clk) begin
		logic [CW-1:0] pm, qm;
		if (adv) begin
			pm = mag_of(p_s2);
			qm = mag_of(q_s2);
			pm_s3  <= pm;
			qm_s3  <= qm;
			dxm_s3 <= mag_of(dx_s2);
			dym_s3 <= mag_of(dy_s2);
			lxm_s3 <= mag_of({lx_s2[CW-1], lx_s2});
			rxm_s3 <= mag_of({rx_s2[CW-1], rx_s2});
			side_s3.lx     <= lx_s2;
			side_s3.rx     <= rx_s2;
			side_s3.thr    <= thr_s2;
			side_s3.ldeg   <= ({pm, 1'b0} < {{(CW+1-THR_W){1'b0}}, thr_s2}) || (pm == '0);
			side_s3.rdeg   <= ({qm, 1'b0} < {{(CW+1-THR_W){1'b0}}, thr_s2}) || (qm == '0);
			side_s3.peq    <= (p_s2 == q_s2);
			side_s3.pqneg  <= p_s2[CW] ^ q_s2[CW];
			side_s3.qlxneg <= q_s2[CW] ^ lx_s2[CW-1];
			side_s3.prxneg <= p_s2[CW] ^ rx_s2[CW-1];
			side_s3.dm     <= mag_of(qmp_s2);
			side_s3.dneg   <= qmp_s2[CW];
		end
	end

	// Stages 4-5: first rank of products.
	pbx_mul u_mul_dx2 (.clk(clk), .adv(adv), .a(dxm_s3), .b(dxm_s3), .p(dx2_p));
	pbx_mul u_mul_dy2 (.clk(clk), .adv(adv), .a(dym_s3), .b(dym_s3), .p(dy2_p));
	pbx_mul u_mul_pq  (.clk(clk), .adv(adv), .a(pm_s3),  .b(qm_s3),  .p(pq_p));
	pbx_mul u_mul_qlx (.clk(clk), .adv(adv), .a(qm_s3),  .b(lxm_s3), .p(qlx_p));
	pbx_mul u_mul_prx (.clk(clk), .adv(adv), .a(pm_s3),  .b(rxm_s3), .p(prx_p));

	// Stage 6: squared distance and the root numerator base N.
	always_ff @(posedge clk) begin
		logic signed [N_W-1:0] qlx_sg, prx_sg;
		if (adv) begin
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			qlx_sg = side_s5.qlxneg ? -$signed({2'b00, qlx_p}) : $signed({2'b00, qlx_p});
			prx_sg = side_s5.prxneg ? -$signed({2'b00, prx_p}) : $signed({2'b00, prx_p});
			r_s6    <= {1'b0, dx2_p} + {1'b0, dy2_p};
			pq_s6   <= pq_p;
			n_s6    <= qlx_sg - prx_sg;
			side_s6 <= side_s5;
		end
	end

	// Stages 7-8: threshold times PQ, and PQ times R split into word products.
	pbx_mul u_mul_eplo (.clk(clk), .adv(adv),
		.a({{(MAG_W-THR_W){1'b0}}, side_s6.thr}), .b(pq_s6[CW-1:0]), .p(eplo_p));
	pbx_mul u_mul_ephi (.clk(clk), .adv(adv),
		.a({{(MAG_W-THR_W){1'b0}}, side_s6.thr}), .b(pq_s6[2*CW-1:CW]), .p(ephi_p));
	pbx_mul u_mul_m0r0 (.clk(clk), .adv(adv),
		.a(pq_s6[CW-1:0]), .b(r_s6[CW-1:0]), .p(m0r0_p));
	pbx_mul u_mul_m0r1 (.clk(clk), .adv(adv),
		.a(pq_s6[CW-1:0]), .b(r_s6[2*CW-1:CW]), .p(m0r1_p));
	pbx_mul u_mul_m1r0 (.clk(clk), .adv(adv),
		.a(pq_s6[2*CW-1:CW]), .b(r_s6[CW-1:0]), .p(m1r0_p));
	pbx_mul u_mul_m1r1 (.clk(clk), .adv(adv),
		.a(pq_s6[2*CW-1:CW]), .b(r_s6[2*CW-1:CW]), .p(m1r1_p));

	// Stage 9: fold the word products into three terms.
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s7    <= r_s6;
			r_s8    <= r_s7;
			pq_s7   <= pq_s6;
			pq_s8   <= pq_s7;
			n_s7    <= n_s6;
			n_s8    <= n_s7;
			side_s7 <= side_s6;
			side_s8 <= side_s7;
			lo_s9   <= m0r0_p;
			mid_s9  <= {1'b0, m0r1_p} + {1'b0, m1r0_p};
			hi_s9   <= {1'b0, m1r1_p} + (r_s8[2*CW] ? {1'b0, pq_s8} : '0);
			ep_s9   <= EP_W'(eplo_p) + (EP_W'(ephi_p) << CW);
			lhs_s9  <= {r_s8, {FRAC_BITS{1'b0}}};
			pqneg_s9 <= side_s8.pqneg;
			n_s9    <= n_s8;
			side_s9 <= side_s8;
		end
	end

	// Stage 10: radicand, discriminant test and case selection.
	always_ff @(posedge clk) begin
		logic            noroot;
		logic [CW:0]     msum;
		if (adv) begin
			rad_s10 <= RAD_W'(lo_s9) + (RAD_W'(mid_s9) << CW) + (RAD_W'(hi_s9) << (2 * CW));
			noroot = pqneg_s9 || (CMP_W'(lhs_s9) < CMP_W'(ep_s9));
			msum   = {side_s9.lx[CW-1], side_s9.lx} + {side_s9.rx[CW-1], side_s9.rx};
			ctx_s10.lx   <= side_s9.lx;
			ctx_s10.rx   <= side_s9.rx;
			ctx_s10.n    <= n_s9;
			ctx_s10.dm   <= side_s9.dm;
			ctx_s10.dneg <= side_s9.dneg;
			priority if (side_s9.ldeg) begin
				ctx_s10.status <= ST_LEFT;
				ctx_s10.alt    <= side_s9.lx;
			end else if (side_s9.rdeg) begin
				ctx_s10.status <= ST_RIGHT;
				ctx_s10.alt    <= side_s9.rx;
			end else if (noroot) begin
				ctx_s10.status <= ST_NOROOT;
				ctx_s10.alt    <= '0;
			end else if (side_s9.peq) begin
				ctx_s10.status <= ST_EQUAL;
				ctx_s10.alt    <= msum[CW:1];
			end else begin
				ctx_s10.status <= ST_NORMAL;
				ctx_s10.alt    <= '0;
			end
		end
	end

	// Advance valid bits with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s1  <= item_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	pbx_solve u_solve (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (v_s10),
		.rad        (rad_s10),
		.ctx        (ctx_s10),
		.out_valid  (fin_valid),
		.out_x      (fin_x),
		.out_status (fin_status),
		.out_sat    (fin_sat)
	);

	// Output register: load a finished result, drop the old one when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && fin_valid) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin_valid) begin
			break_x_q   <= fin_x;
			status_q    <= fin_status;
			saturated_q <= fin_sat;
		end
	end

	assign result_valid = result_valid_q;
	assign break_x      = break_x_q;
	assign status       = status_q;
	assign saturated    = saturated_q;

	`PBX_ASSERT_IMP(a_stall_cause, !item_ready, result_valid && !result_ready,
		"input held back without output backpressure")
	`PBX_ASSERT_NEXT(a_thr_write, wr_en, thr_q == $past(pwdata[THR_W-1:0]),
		"threshold write lost")
	`PBX_ASSERT(a_special_unsat, !result_valid || status == ST_NORMAL || !saturated,
		"saturation flagged on a special case")
	`PBX_ASSERT_IMP(a_noroot_zero, result_valid && status == ST_NOROOT, break_x == '0,
		"no-root result is not zero")

endmodule

// ===== bench/breakpoint_checker.sv =====
// ----------------------------------------------------------------------------
// Breakpoint result checker
// Tracks the threshold register from APB writes, predicts the breakpoint x,
// status and saturation flag of every accepted item, and compares each result
// transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module breakpoint_checker import pbx_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	input  logic                 pready,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  logic signed [CW-1:0] left_x,
	input  logic signed [CW-1:0] left_y,
	input  logic signed [CW-1:0] right_x,
	input  logic signed [CW-1:0] right_y,
	input  logic signed [CW-1:0] sweep_y,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  logic signed [CW-1:0] break_x,
	input  logic [2:0]           status,
	input  logic                 saturated,
	output int                   mismatches,
	output int                   outstanding,
	output int                   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic signed [CW-1:0] bx;
		logic [2:0]           st;
		logic                 sat;
	} breakpoint_t;

	breakpoint_t       pending_breaks[$];
	logic [THR_W-1:0]  thr_shadow;

	assign outstanding = pending_breaks.size();

	function automatic wide_t floor_quot(input wide_t num, input wide_t den);
		wide_t qt;
		qt = num / den;
		if ((num % den) != 0 && ((num < 0) != (den < 0)))
			qt = qt - 1;
		return qt;
	endfunction

	function automatic breakpoint_t solve_breakpoint(
		input logic signed [CW-1:0] lx, ly, rx, ry, sy, input logic [THR_W-1:0] thr);
		breakpoint_t o;
		wide_t p, q, ap, aq, e, dx, dy, r, pq, rad, root, cand, nb, x1, x2, res;
		p  = wide_t'(ly) - wide_t'(sy);
		q  = wide_t'(ry) - wide_t'(sy);
		ap = (p < 0) ? -p : p;
		aq = (q < 0) ? -q : q;
		e  = wide_t'({1'b0, thr});
		o.sat = 1'b0;
		if (2 * ap < e || p == 0) begin
			res  = wide_t'(lx);
			o.st = ST_LEFT;
		end else if (2 * aq < e || q == 0) begin
			res  = wide_t'(rx);
			o.st = ST_RIGHT;
		end else begin
			dx = wide_t'(lx) - wide_t'(rx);
			dy = p - q;
			r  = dx * dx + dy * dy;
			pq = p * q;
			if (pq < 0 || r * (wide_t'(1) <<< FRAC_BITS) < e * pq) begin
				res  = 0;
				o.st = ST_NOROOT;
			end else if (p == q) begin
				res  = (wide_t'(lx) + wide_t'(rx)) >>> 1;
				o.st = ST_EQUAL;
			end else begin
				// floor square root, one bit at a time from the top
				rad  = pq * r;
				root = 0;
				for (int i = 95; i >= 0; i--) begin
					cand = root | (wide_t'(1) <<< i);
					if (cand * cand <= rad)
						root = cand;
				end
				nb = q * wide_t'(lx) - p * wide_t'(rx);
				x1 = floor_quot(nb + root, q - p);
				x2 = floor_quot(nb - root, q - p);
				res  = (wide_t'(lx) < x1 && x1 < wide_t'(rx)) ? x1 : x2;
				o.st = ST_NORMAL;
			end
		end
		if (res > wide_t'(X_MAX)) begin
			res   = wide_t'(X_MAX);
			o.sat = 1'b1;
		end else if (res < wide_t'(X_MIN)) begin
			res   = wide_t'(X_MIN);
			o.sat = 1'b1;
		end
		o.bx = res[CW-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		breakpoint_t want;
		if (!arst_n) begin
			thr_shadow <= THR_RESET;
			pending_breaks.delete();
			mismatches <= 0;
			checked    <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_THR)
				thr_shadow <= pwdata[THR_W-1:0];
			if (item_valid && item_ready)
				pending_breaks.push_back(solve_breakpoint(left_x, left_y, right_x,
					right_y, sweep_y, thr_shadow));
			if (result_valid && result_ready) begin
				checked <= checked + 1;
				if (pending_breaks.size() == 0) begin
					if (mismatches < 10)
						$display("%t unexpected result: break_x=%0d status=%0d",
							$realtime, break_x, status);
					mismatches <= mismatches + 1;
				end else begin
					want = pending_breaks.pop_front();
					if (want.bx !== break_x || want.st !== status || want.sat !== saturated) begin
						if (mismatches < 10)
							$display("%t mismatch: exp x=%0d st=%0d sat=%0b got x=%0d st=%0d sat=%0b",
								$realtime, want.bx, want.st, want.sat, break_x, status, saturated);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

// ===== bench/parabola_breakpoint_x_tb.sv =====
// ----------------------------------------------------------------------------
// Breakpoint block testbench
// Drives site and sweep transactions with random gaps and output stalls over
// several threshold settings; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module parabola_breakpoint_x_tb import pbx_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT  = 1000000;
	localparam int SETTLE = 200;	// beyond the pipeline latency

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	logic signed [CW-1:0] left_x = '0, left_y = '0, right_x = '0, right_y = '0, sweep_y = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic signed [CW-1:0] break_x;
	logic [2:0]           status;
	logic                 saturated;

	int mismatches, outstanding, checked;
	int cycles = 0;
	int items_sent = 0;
	bit no_idle = 1'b0;	// burst stretch: no gaps and no stalls

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	parabola_breakpoint_x u_top (.*);

	breakpoint_checker u_checker (.*);

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("parabola_breakpoint_x_tb NOT OK");
			$finish;
		end
	end

	// Stall the result side at random; mostly short stalls, a few long ones.
	initial begin
		int pick;
		@(posedge arst_n);
		forever begin
			pick = $urandom_range(0, 99);
			if (!no_idle && pick < 30) begin
				result_ready <= 1'b0;
				repeat (pick < 27 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Setup cycle, then access cycle; the register takes the value at the
	// edge that ends the access cycle.
	task automatic write_threshold(input logic [THR_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_THR, 2'b00};
		pwdata  <= DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Hold the transaction until accepted, then sometimes drop valid for a random gap.
	task automatic send_sites(input logic signed [CW-1:0] lx, ly, rx, ry, sy);
		bit hs;
		int pick;
		left_x     <= lx;
		left_y     <= ly;
		right_x    <= rx;
		right_y    <= ry;
		sweep_y    <= sy;
		item_valid <= 1'b1;
		do begin
			@(negedge clk);
			hs = item_ready;
			@(posedge clk);
		end while (!hs);
		items_sent++;
		pick = $urandom_range(0, 99);
		if (!no_idle && pick < 40) begin
			item_valid <= 1'b0;
			repeat (pick < 36 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
		end
	endtask

	// Wait for every prediction to be matched, then let the pipe settle.
	task automatic drain;
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] edge_coord();
		case ($urandom_range(0, 5))
			0: return X_MAX;
			1: return X_MIN;
			2: return '0;
			3: return -1;
			4: return 1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-placed site pairs with random content, the rest raw noise
	// and extremes.
	task automatic send_random;
		logic signed [CW-1:0] sy, lx, rx, ly, ry;
		int kind, span;
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			span = $urandom_range(8, 28);
			sy = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
			lx = $signed($urandom_range(0, 1 << span)) - (1 << (span - 1));
			rx = $signed($urandom_range(0, 1 << span)) - (1 << (span - 1));
			ly = sy + (($urandom & 1) ? 1 : -1) * $signed($urandom_range(1, 1 << span));
			ry = ($urandom_range(0, 9) == 0) ? ly
				: sy + ((ly > sy) ? 1 : -1) * $signed($urandom_range(1, 1 << span));
			if ($urandom_range(0, 9) == 0)
				ly = sy + $signed($urandom_range(0, 4)) - 2;
			if ($urandom_range(0, 9) == 0)
				ry = sy + $signed($urandom_range(0, 4)) - 2;
			if ($urandom_range(0, 9) == 0)
				ry = sy - (ly - sy);	// sites on opposite sides
			send_sites(lx, ly, rx, ry, sy);
		end else if (kind < 85)
			send_sites($urandom, $urandom, $urandom, $urandom, $urandom);
		else
			send_sites(edge_coord(), edge_coord(), edge_coord(), edge_coord(), edge_coord());
	endtask

	task automatic send_directed;
		localparam logic signed [CW-1:0] ONE = 1 << FRAC_BITS;
		send_sites(-ONE, ONE, ONE, 2 * ONE, 0);		// normal
		send_sites(ONE, 3 * ONE, -ONE, ONE, 0);		// normal, other root
		send_sites(5 * ONE, ONE, 7 * ONE, 2 * ONE, ONE);	// left on sweep line
		send_sites(5 * ONE, 2 * ONE, 7 * ONE, 0, 0);	// right on sweep line
		send_sites(0, 1, ONE, ONE, 0);			// left one step above sweep line
		send_sites(0, ONE, ONE, -1, 0);			// right one step below sweep line
		send_sites(0, ONE, ONE, -ONE, 0);		// opposite sides, no root
		send_sites(3, ONE, 8, ONE, 0);			// equal heights, odd sum
		send_sites(-3, -ONE, -8, -ONE, 0);		// equal heights, negative
		send_sites(X_MAX, X_MAX, X_MAX, X_MAX, X_MIN);	// extremes, equal heights
		send_sites(X_MIN, X_MAX, X_MAX, X_MIN, 0);
		send_sites(X_MIN, X_MAX, X_MAX, X_MAX - 1, X_MIN);	// huge roots, saturation
		send_sites(X_MAX, X_MIN, X_MIN, X_MIN + 1, X_MAX);
		send_sites(X_MIN, X_MIN, X_MIN, X_MIN, X_MIN);	// all on sweep line
		send_sites(0, 0, 0, 0, 0);
		send_sites(-1, -1, -1, -1, -1);
		send_sites(0, ONE, 0, 2 * ONE, 0);		// coincident x
		send_sites(ONE, 2, -ONE, 3, 0);			// tiny heights, small disc
		send_sites(1, ONE, 0, ONE + 1, 0);		// near-equal heights
	endtask

	initial begin
		logic [THR_W-1:0] thr_plan[5];
		thr_plan = '{THR_RESET, 16'd0, 16'hFFFF, 16'd300, 16'($urandom)};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (thr_plan[k]) begin
			// Change the threshold only while the pipe is empty.
			write_threshold(thr_plan[k]);
			if (k < 3)
				send_directed();
			no_idle = (k == 3);
			repeat (190) send_random();
			drain();
		end

		$display("covered %0d site transactions, %0d results checked, over %0d thresholds",
			items_sent, checked, $size(thr_plan));
		$display("thresholds included 0 and full scale; gaps, stalls and burst stretches mixed");
		if (mismatches == 0 && outstanding == 0)
			$display("parabola_breakpoint_x_tb OK");
		else
			$display("parabola_breakpoint_x_tb NOT OK");
		$finish;
	end

endmodule
